FILE: rtl/ulsd_pkg.sv
// ----------------------------------------------------------------------------
// ulsd_pkg
// Shared types, constants and decode functions of the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package ulsd_pkg;

	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	localparam logic [7:0] MASK_LEAD2  = 8'hE0;
	localparam logic [7:0] CODE_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3  = 8'hF0;
	localparam logic [7:0] CODE_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4  = 8'hF8;
	localparam logic [7:0] CODE_LEAD4  = 8'hF0;

	localparam logic [2:0] LEN_INVALID = 3'd0;
	localparam logic [2:0] LEN_ONE     = 3'd1;
	localparam logic [2:0] LEN_TWO     = 3'd2;
	localparam logic [2:0] LEN_THREE   = 3'd3;
	localparam logic [2:0] LEN_FOUR    = 3'd4;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            last;
	} job_t;

	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  used;
	} dec_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0) begin
			len = LEN_ONE;
		end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
			len = LEN_TWO;
		end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
			len = LEN_THREE;
		end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
			len = LEN_FOUR;
		end else begin
			len = LEN_INVALID;
		end
		return len;
	endfunction

	function automatic dec_t decode_one(input logic [3:0][7:0] b, input logic [2:0] avail);
		dec_t       d;
		logic [2:0] len;
		len    = lead_length(b[0]);
		d.cp   = REPLACEMENT_CP;
		d.used = LEN_ONE;
		if (len == LEN_ONE) begin
			d.cp = {13'd0, b[0]};
		end else if (len == LEN_TWO && avail >= LEN_TWO) begin
			d.cp   = {10'd0, b[0][4:0], b[1][5:0]};
			d.used = LEN_TWO;
		end else if (len == LEN_THREE && avail >= LEN_THREE) begin
			d.cp   = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
			d.used = LEN_THREE;
		end else if (len == LEN_FOUR && avail >= LEN_FOUR) begin
			d.cp   = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
			d.used = LEN_FOUR;
		end
		return d;
	endfunction

endpackage

FILE: rtl/ulsd_if.sv
// ----------------------------------------------------------------------------
// ulsd_if
// Valid/ready channels of the decoder: raw bytes in, code points out.
// ----------------------------------------------------------------------------
interface ulsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       string_end;

	modport source (output valid, output text_byte, output string_end, input ready);
	modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface ulsd_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  bytes_used;
	logic        final_of_string;

	modport source (output valid, output code_point, output bytes_used,
		output final_of_string, input ready);
	modport sink   (input valid, input code_point, input bytes_used,
		input final_of_string, output ready);
endinterface

FILE: rtl/ulsd_front.sv
// ----------------------------------------------------------------------------
// ulsd_front
// Accepts bytes, gathers multi-byte sequences and pushes decode jobs.
// ----------------------------------------------------------------------------
module ulsd_front (
	input  logic             clk,
	input  logic             arst_n,
	ulsd_byte_if.sink        byte_ch,
	input  logic             full,
	output logic             push,
	output ulsd_pkg::job_t   job
);
	import ulsd_pkg::*;

	logic [7:0] held_q [3];
	logic [1:0] held_count_q;
	logic [2:0] seq_len_q;

	logic       accept;
	logic [2:0] len;
	logic [2:0] n;
	logic       complete;

	assign byte_ch.ready = !full;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign len           = lead_length(byte_ch.text_byte);
	assign n             = {1'b0, held_count_q} + 3'd1;
	assign complete      = (n >= seq_len_q) || (n == LEN_FOUR);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			job.bytes[i] = (2'(i) < held_count_q) ? held_q[i] : byte_ch.text_byte;
		end
		job.bytes[3] = byte_ch.text_byte;
		job.count    = n;
		job.last     = byte_ch.string_end;
	end

	always_comb begin
		push = 1'b0;
		if (accept) begin
			if (byte_ch.string_end) begin
				push = 1'b1;
			end else if (held_count_q == 2'd0) begin
				push = (len == LEN_ONE) || (len == LEN_INVALID);
			end else begin
				push = complete;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			seq_len_q    <= LEN_ONE;
		end else if (accept) begin
			if (push) begin
				held_count_q <= 2'd0;
				seq_len_q    <= LEN_ONE;
			end else begin
				held_count_q <= n[1:0];
				if (held_count_q == 2'd0) begin
					seq_len_q <= len;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !push && held_count_q != 2'd3) begin
			held_q[held_count_q] <= byte_ch.text_byte;
		end
	end

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd0 |-> {1'b0, held_count_q} < seq_len_q)
		else $error("held bytes reached sequence length");

	a_held_lead_valid: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd0 |-> seq_len_q >= LEN_TWO && seq_len_q <= LEN_FOUR)
		else $error("bytes held without a multi-byte lead");

endmodule

FILE: rtl/ulsd_queue.sv
// ----------------------------------------------------------------------------
// ulsd_queue
// Small job queue between the byte front end and the decode back end.
// ----------------------------------------------------------------------------
module ulsd_queue #(
	parameter int unsigned DEPTH = ulsd_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ulsd_pkg::job_t   push_job,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output ulsd_pkg::job_t   head_job
);
	import ulsd_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CntW'(push) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !head_valid))
		else $error("queue overflow or underflow");

endmodule

FILE: rtl/ulsd_back.sv
// ----------------------------------------------------------------------------
// ulsd_back
// Decodes jobs into the output register, one code point per unstalled cycle.
// ----------------------------------------------------------------------------
module ulsd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  ulsd_pkg::job_t   head_job,
	output logic             pop,
	ulsd_cp_if.source        cp_ch
);
	import ulsd_pkg::*;

	logic [1:0]      offset_q;
	logic            out_valid_q;
	logic [20:0]     cp_q;
	logic [2:0]      used_q;
	logic            final_q;

	logic [3:0][7:0] window;
	logic [2:0]      avail;
	dec_t            dec;
	logic [2:0]      next_off;
	logic            done;
	logic            fire;

	assign window   = head_job.bytes >> {offset_q, 3'b000};
	assign avail    = head_job.count - {1'b0, offset_q};
	assign dec      = decode_one(window, avail);
	assign next_off = {1'b0, offset_q} + dec.used;
	assign done     = (next_off >= head_job.count);
	assign fire     = head_valid && (!out_valid_q || cp_ch.ready);
	assign pop      = fire && done;

	assign cp_ch.valid           = out_valid_q;
	assign cp_ch.code_point      = cp_q;
	assign cp_ch.bytes_used      = used_q;
	assign cp_ch.final_of_string = final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				offset_q    <= done ? 2'd0 : next_off[1:0];
			end else if (cp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cp_q    <= dec.cp;
			used_q  <= dec.used;
			final_q <= done && head_job.last;
		end
	end

	a_offset_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, offset_q} < head_job.count)
		else $error("decode offset beyond job");

	a_split_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !done |-> head_job.last && dec.used == LEN_ONE)
		else $error("job split outside a string end");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> used_q >= LEN_ONE && used_q <= LEN_FOUR)
		else $error("bytes_used out of range");

endmodule

FILE: rtl/lenient_utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// lenient_utf8_stream_decoder
// Lenient UTF-8 decoder: string bytes in, code points out.
// ----------------------------------------------------------------------------
// byte_ch carries one byte per word with string_end on the final byte of a
// string. cp_ch carries one code point per word with the number of bytes it
// used and final_of_string on the last code point of the string.
// The front end takes one byte per cycle while the queue is not full; a byte
// that completes a sequence, or a single-byte character, yields a code point
// via the job queue and the output register. Bytes inside a sequence yield
// nothing until the sequence ends. A string that ends inside a sequence yields
// up to three code points, one per cycle from the back end while cp_ch is not
// stalled, so the front end may stall. With cp_ch unstalled the sustained
// rate is one byte per cycle, set by the back end's decode step and the queue.
// Reset clears held bytes and the queue; the output is empty after reset.
// When cp_ch stalls, the output register holds its word, the queue fills,
// and byte_ch.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module lenient_utf8_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = ulsd_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	ulsd_byte_if.sink   byte_ch,
	ulsd_cp_if.source   cp_ch
);
	import ulsd_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	ulsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.full    (full),
		.push    (push),
		.job     (push_job)
	);

	ulsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ulsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.cp_ch      (cp_ch)
	);

endmodule

FILE: tb/lenient_utf8_stream_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lenient_utf8_stream_decoder_test
// Drives byte strings into the lenient UTF-8 decoder and checks every code
// point word against a cycle-free prediction: directed corner strings first
// (extremes, every sequence length, invalid leads, overlong and surrogate
// forms, strings cut inside a sequence), then random strings built mostly
// from well-formed sequences with random content, mixed with noise bytes
// and broken sequences. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module lenient_utf8_stream_decoder_test;

	localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
	localparam int          RANDOM_BYTES     = 240;
	localparam int          WATCHDOG_LIMIT   = 2000;
	localparam int          SETTLE_CYCLES    = 20;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       drain;
	} text_word_t;

	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  used;
		logic        ends_string;
	} cp_word_t;

	logic clk;
	logic arst_n;

	ulsd_byte_if byte_ch();
	ulsd_cp_if   cp_ch();

	lenient_utf8_stream_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.cp_ch  (cp_ch)
	);

	text_word_t text_stream[$];
	cp_word_t   due_code_points[$];
	logic [7:0] text_buf[$];

	logic [7:0] pend_bytes[0:2];
	int         pend_n;
	int         pend_span;

	logic byte_taken;
	int   tx_gap;
	int   rx_hold;
	bit   steady_tx;
	bit   steady_rx;
	int   mismatches;
	int   idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int lead_span(input logic [7:0] b);
		if (!b[7])
			return 1;
		if (b[7:5] == 3'b110)
			return 2;
		if (b[7:4] == 4'b1110)
			return 3;
		if (b[7:3] == 5'b11110)
			return 4;
		return 0;
	endfunction

	function automatic cp_word_t decode_at(input logic [3:0][7:0] w, input int avail);
		cp_word_t r;
		int       span;
		span          = lead_span(w[0]);
		r.cp          = REPLACEMENT_CHAR;
		r.used        = 3'd1;
		r.ends_string = 1'b0;
		if (span == 1) begin
			r.cp = {13'd0, w[0]};
		end else if (span == 2 && avail >= 2) begin
			r.cp   = {10'd0, w[0][4:0], w[1][5:0]};
			r.used = 3'd2;
		end else if (span == 3 && avail >= 3) begin
			r.cp   = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
			r.used = 3'd3;
		end else if (span == 4 && avail >= 4) begin
			r.cp   = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
			r.used = 3'd4;
		end
		return r;
	endfunction

	// Advance the decode state by one accepted byte and queue what it yields.
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		logic [3:0][7:0] win;
		int              n;
		int              pos;
		int              i;
		cp_word_t        w;
		win = '0;
		for (i = 0; i < pend_n; i++)
			win[i] = pend_bytes[i];
		win[pend_n] = b;
		n = pend_n + 1;
		if (fin) begin
			// re-decode whatever is left after a cut lead
			pos = 0;
			while (pos < n) begin
				w             = decode_at(win >> (8 * pos), n - pos);
				pos           = pos + w.used;
				w.ends_string = (pos >= n);
				due_code_points.push_back(w);
			end
			pend_n    = 0;
			pend_span = 1;
		end else if (pend_n == 0 && lead_span(b) <= 1) begin
			due_code_points.push_back(decode_at(win, 1));
		end else if (pend_n == 0) begin
			pend_bytes[0] = b;
			pend_n        = 1;
			pend_span     = lead_span(b);
		end else if (n >= pend_span) begin
			due_code_points.push_back(decode_at(win, n));
			pend_n    = 0;
			pend_span = 1;
		end else begin
			pend_bytes[pend_n] = b;
			pend_n             = n;
		end
	endtask

	function automatic int idle_span();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic add_word(input logic [7:0] b, input logic fin, input logic drain);
		text_word_t t;
		t.b     = b;
		t.fin   = fin;
		t.drain = drain;
		text_stream.push_back(t);
	endtask

	// Push the low n bytes of a literal, most significant first.
	task automatic add_bytes(input logic [31:0] bytes, input int n, input logic fin);
		int i;
		for (i = n - 1; i >= 0; i--)
			add_word(bytes[8 * i +: 8], fin && i == 0, 1'b0);
	endtask

	task automatic put_sequence(input int span, input int keep);
		logic [31:0] r;
		logic [7:0]  lead;
		int          i;
		r = $urandom;
		case (span)
			1: begin
				lead = {1'b0, r[6:0]};
			end
			2: begin
				lead = {3'b110, r[4:0]};
			end
			3: begin
				lead = {4'b1110, r[3:0]};
			end
			default: begin
				lead = {5'b11110, r[2:0]};
			end
		endcase
		text_buf.push_back(lead);
		for (i = 1; i < keep; i++) begin
			r = $urandom;
			if (r[31:28] == 4'd0)
				text_buf.push_back(r[7:0]);
			else
				text_buf.push_back({2'b10, r[5:0]});
		end
	endtask

	task automatic add_random_string(input logic drain);
		int chars;
		int kind;
		int span;
		int i;
		text_buf.delete();
		chars = $urandom_range(1, 8);
		repeat (chars) begin
			kind = $urandom_range(0, 99);
			span = $urandom_range(1, 4);
			if (kind < 70)
				put_sequence(span, span);
			else if (kind < 85)
				text_buf.push_back(8'($urandom_range(0, 255)));
			else
				put_sequence(span, $urandom_range(1, span > 1 ? span - 1 : 1));
		end
		// cut the string inside a sequence
		if ($urandom_range(0, 3) == 0) begin
			span = $urandom_range(2, 4);
			put_sequence(span, $urandom_range(1, span - 1));
		end
		for (i = 0; i < text_buf.size(); i++)
			add_word(text_buf[i], i == text_buf.size() - 1, drain && i == 0);
	endtask

	always @(negedge clk) begin : text_drive
		logic send;
		send = 1'b0;
		if (arst_n) begin
			if ($urandom_range(0, 49) == 0)
				steady_tx = !steady_tx;
			if (byte_taken) begin
				void'(text_stream.pop_front());
				tx_gap = (steady_tx || $urandom_range(0, 99) < 55) ? 0 : idle_span();
			end
			if (tx_gap > 0)
				tx_gap--;
			else if (text_stream.size() > 0)
				send = !(text_stream[0].drain && due_code_points.size() != 0);
			if (send) begin
				byte_ch.valid      <= 1'b1;
				byte_ch.text_byte  <= text_stream[0].b;
				byte_ch.string_end <= text_stream[0].fin;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 49) == 0)
				steady_rx = !steady_rx;
			if (rx_hold > 0) begin
				cp_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				cp_ch.ready <= 1'b1;
				if (!steady_rx && $urandom_range(0, 99) < 15)
					rx_hold = idle_span();
			end
		end
	end

	always @(posedge clk) begin : cp_check
		cp_word_t want;
		logic     cp_taken;
		logic     in_taken;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			in_taken   = byte_ch.valid && byte_ch.ready;
			cp_taken   = cp_ch.valid && cp_ch.ready;
			byte_taken <= in_taken;
			if (cp_taken) begin
				if (due_code_points.size() == 0) begin
					$display("%0t: unexpected word cp=%h used=%0d end=%b", $time,
						cp_ch.code_point, cp_ch.bytes_used, cp_ch.final_of_string);
					mismatches++;
				end else begin
					want = due_code_points.pop_front();
					if (cp_ch.code_point !== want.cp || cp_ch.bytes_used !== want.used
							|| cp_ch.final_of_string !== want.ends_string) begin
						$display("%0t: mismatch expected cp=%h used=%0d end=%b, got cp=%h used=%0d end=%b",
							$time, want.cp, want.used, want.ends_string,
							cp_ch.code_point, cp_ch.bytes_used, cp_ch.final_of_string);
						mismatches++;
					end
				end
			end
			if (in_taken)
				decode_byte(byte_ch.text_byte, byte_ch.string_end);
			if (in_taken || cp_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int directed;
		clk                = 1'b0;
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.text_byte  = 8'h00;
		byte_ch.string_end = 1'b0;
		cp_ch.ready        = 1'b0;
		byte_taken         = 1'b0;
		tx_gap             = 0;
		rx_hold            = 0;
		steady_tx          = 1'b0;
		steady_rx          = 1'b0;
		mismatches         = 0;
		idle_cycles        = 0;
		pend_n             = 0;
		pend_span          = 1;

		add_bytes(32'h0000007F, 2, 1'b0);
		add_bytes(32'h00E282AC, 3, 1'b0);
		add_bytes(32'hF7BFBFBF, 4, 1'b1);
		add_bytes(32'h0080F8FF, 3, 1'b0);
		add_bytes(32'h0000C080, 2, 1'b0);
		add_bytes(32'h00EDA080, 3, 1'b0);
		add_bytes(32'h0000E282, 2, 1'b1);
		add_bytes(32'h00F041C3, 3, 1'b1);
		add_bytes(32'h000000C3, 1, 1'b1);
		add_bytes(32'h00000000, 1, 1'b1);
		directed = text_stream.size();

		// hold the first random string until the directed words have drained
		add_random_string(1'b1);
		while (text_stream.size() < directed + RANDOM_BYTES)
			add_random_string($urandom_range(0, 49) == 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (text_stream.size() != 0)
			@(posedge clk);
		while (due_code_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: lenient_utf8_stream_decoder.f
rtl/ulsd_pkg.sv
rtl/ulsd_if.sv
rtl/ulsd_front.sv
rtl/ulsd_queue.sv
rtl/ulsd_back.sv
rtl/lenient_utf8_stream_decoder.sv
tb/lenient_utf8_stream_decoder_test.sv
